[src/elab_pkg.sv]
// Package: shared request/response types and operation and status codes.
`default_nettype none

package elab_pkg;

    localparam int ID_W    = 10;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int DEGO_W  = 7;
    localparam int EDGE_W  = 16;
    localparam int IDC_W   = 11;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_SUM  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_SLOT  = 2'd3;

    localparam logic [EDGE_W-1:0] EDGE_SAT = '1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   node_a;
        logic [ID_W-1:0]   node_b;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   neighbor;
        logic [DEGO_W-1:0] node_degree;
        logic [ID_W-1:0]   max_id;
        logic [ID_W-1:0]   min_id;
        logic [EDGE_W-1:0] edge_count;
        logic [IDC_W-1:0]  id_count;
        logic [DEGO_W-1:0] degree_max;
        logic [DEGO_W-1:0] degree_min;
    } t_rsp;

endpackage

`default_nettype wire

[src/elab_chan_if.sv]
// Interface: valid/ready channel carrying one request or response payload.
`default_nettype none

interface elab_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/elab_ram.sv]
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module elab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

[src/edge_list_adjacency_builder.sv]
// Top level: undirected adjacency table built from edges, with reads and a summary walk.
//
// Usage: requests arrive on i_req (operation, node_a, node_b, slot) and each one
// gives exactly one response on o_rsp. Both channels move a request when valid
// and ready are high at a rising clock edge.
// The block handles one request at a time. Degrees live in a NODES-deep RAM and
// neighbor lists in a NODES*MAX_DEGREE-deep RAM, both with registered reads; the
// degree RAM's single read port orders the steps:
//   add edge ............ both degree reads, then both writes (none if a list is full)
//   read neighbor ....... degree read, then list read (skipped if the slot is past the degree)
//   summary ............. a degree read for each id up to the largest; none with no edges
//   rejected id or op 3 . no memory access
// The next request is taken in the cycle after the load.
// After reset the degree RAM is swept to zero, one entry per cycle; i_req.ready
// stays low until the sweep ends.
// The response sits in an output register; when the receiver stalls, the block
// still takes the next request and works on it, holding its result until the
// output register frees up.
`default_nettype none

module edge_list_adjacency_builder #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    elab_chan_if.sink   i_req,
    elab_chan_if.source o_rsp
);
    import elab_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(NODES * MAX_DEGREE);
    localparam int CW = $clog2(NODES + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A     = 4'd2;
    localparam logic [3:0] S_B     = 4'd3;
    localparam logic [3:0] S_W     = 4'd4;
    localparam logic [3:0] S_RA    = 4'd5;
    localparam logic [3:0] S_RN    = 4'd6;
    localparam logic [3:0] S_RN2   = 4'd7;
    localparam logic [3:0] S_WALK  = 4'd8;
    localparam logic [3:0] S_WTAIL = 4'd9;
    localparam logic [3:0] S_WFIN  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // control state
    logic [3:0]        r_state;
    logic [NW-1:0]     r_clr;
    logic              r_ovalid;
    logic              r_wv;
    // graph-wide state
    logic [EDGE_W-1:0] r_edge_total;
    logic [ID_W-1:0]   r_largest;
    logic [ID_W-1:0]   r_smallest;
    logic              r_any;
    // request and work registers
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_a;
    logic [ID_W-1:0]   r_b;
    logic [SLOT_W-1:0] r_slot;
    logic [DW-1:0]     r_da;
    logic [DW-1:0]     r_db;
    logic [AW-1:0]     r_base;
    logic [ID_W-1:0]   r_j;
    logic [DW-1:0]     r_dmax;
    logic [DW-1:0]     r_dmin;
    logic [CW-1:0]     r_idc;
    t_rsp              r_res;
    t_rsp              r_out;

    // memory ports
    logic              deg_we;
    logic [NW-1:0]     deg_waddr;
    logic [DW-1:0]     deg_wdata;
    logic [NW-1:0]     deg_raddr;
    logic [DW-1:0]     w_deg_rd;
    logic              nbr_we;
    logic [AW-1:0]     nbr_waddr;
    logic [ID_W-1:0]   nbr_wdata;
    logic [AW-1:0]     nbr_raddr;
    logic [ID_W-1:0]   w_nbr_rd;

    logic              w_acc;
    logic              w_a_ok;
    logic              w_b_ok;
    logic              w_self;
    logic              w_full;
    logic [DW-1:0]     w_db;
    logic [ID_W-1:0]   w_hi;
    logic [ID_W-1:0]   w_lo;
    logic [ID_W-1:0]   w_new_hi;
    logic [ID_W-1:0]   w_new_lo;
    logic              w_out_free;

    elab_ram #(.WIDTH(DW), .DEPTH(NODES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (w_deg_rd)
    );

    elab_ram #(.WIDTH(ID_W), .DEPTH(NODES * MAX_DEGREE)) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_raddr (nbr_raddr),
        .o_rdata (w_nbr_rd)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    assign w_acc      = i_req.valid && (r_state == S_IDLE);
    assign w_a_ok     = 32'(i_req.data.node_a) < NODES;
    assign w_b_ok     = 32'(i_req.data.node_b) < NODES;
    assign w_out_free = !r_ovalid || o_rsp.ready;

    // second degree read lands in S_B; a self-loop sees its own first increment
    assign w_self = (r_a == r_b);
    assign w_full = w_self ? (32'(r_da) + 32'd2 > MAX_DEGREE)
                           : (32'(r_da) >= MAX_DEGREE || 32'(w_deg_rd) >= MAX_DEGREE);
    assign w_db   = w_self ? DW'(32'(r_da) + 32'd1) : w_deg_rd;

    assign w_hi     = (r_a > r_b) ? r_a : r_b;
    assign w_lo     = (r_a < r_b) ? r_a : r_b;
    assign w_new_hi = (!r_any || w_hi > r_largest)  ? w_hi : r_largest;
    assign w_new_lo = (!r_any || w_lo < r_smallest) ? w_lo : r_smallest;

    // memory port steering
    always_comb begin
        deg_we    = 1'b0;
        deg_waddr = NW'(r_a);
        deg_wdata = DW'(32'(r_da) + 32'd1);
        deg_raddr = NW'(i_req.data.node_a);
        nbr_we    = 1'b0;
        nbr_waddr = r_base + AW'(r_da);
        nbr_wdata = r_b;
        nbr_raddr = r_base + AW'(r_slot);
        case (r_state)
            S_CLEAR: begin
                deg_we    = 1'b1;
                deg_waddr = r_clr;
                deg_wdata = '0;
            end
            S_A: begin
                deg_raddr = NW'(r_b);
            end
            S_B: begin
                deg_we = !w_full;
                nbr_we = !w_full;
            end
            S_W: begin
                deg_we    = 1'b1;
                deg_waddr = NW'(r_b);
                deg_wdata = DW'(32'(r_db) + 32'd1);
                nbr_we    = 1'b1;
                nbr_waddr = r_base + AW'(r_db);
                nbr_wdata = r_a;
            end
            S_WALK: begin
                deg_raddr = NW'(r_j);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_ovalid     <= 1'b0;
            r_wv         <= 1'b0;
            r_edge_total <= '0;
            r_largest    <= '0;
            r_smallest   <= '1;
            r_any        <= 1'b0;
        end else begin
            r_wv <= (r_state == S_WALK);

            // fold in the degree read issued in the previous cycle
            if (r_wv) begin
                if (w_deg_rd > r_dmax) r_dmax <= w_deg_rd;
                if (w_deg_rd < r_dmin) r_dmin <= w_deg_rd;
                if (w_deg_rd != '0)    r_idc  <= r_idc + CW'(1);
            end

            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                    if (32'(r_clr) == NODES - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_op   <= i_req.data.operation;
                        r_a    <= i_req.data.node_a;
                        r_b    <= i_req.data.node_b;
                        r_slot <= i_req.data.slot;
                        r_res  <= '0;
                        case (i_req.data.operation)
                            OP_ADD: begin
                                if (w_a_ok && w_b_ok) begin
                                    r_state <= S_A;
                                end else begin
                                    r_res.status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end
                            end
                            OP_READ: begin
                                if (w_a_ok) begin
                                    r_state <= S_RA;
                                end else begin
                                    r_res.status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end
                            end
                            OP_SUM: begin
                                r_j    <= '0;
                                r_dmax <= '0;
                                r_dmin <= '1;
                                r_idc  <= '0;
                                r_state <= r_any ? S_WALK : S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_A: begin
                    r_da    <= w_deg_rd;
                    r_base  <= AW'(32'(NW'(r_a)) * MAX_DEGREE);
                    r_state <= S_B;
                end
                S_B: begin
                    if (w_full) begin
                        r_res.status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_db    <= w_db;
                        r_base  <= AW'(32'(NW'(r_b)) * MAX_DEGREE);
                        r_state <= S_W;
                    end
                end
                S_W: begin
                    if (r_edge_total != EDGE_SAT) begin
                        r_edge_total <= r_edge_total + EDGE_W'(1);
                    end
                    r_largest  <= w_new_hi;
                    r_smallest <= w_new_lo;
                    r_any      <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_RA: begin
                    r_da              <= w_deg_rd;
                    r_res.node_degree <= DEGO_W'(w_deg_rd);
                    if (32'(r_slot) >= 32'(w_deg_rd)) begin
                        r_res.status <= ST_SLOT;
                        r_state      <= S_DONE;
                    end else begin
                        r_base  <= AW'(32'(NW'(r_a)) * MAX_DEGREE);
                        r_state <= S_RN;
                    end
                end
                S_RN: begin
                    r_state <= S_RN2;
                end
                S_RN2: begin
                    r_res.neighbor <= w_nbr_rd;
                    r_state        <= S_DONE;
                end
                S_WALK: begin
                    if (r_j == r_largest) begin
                        r_state <= S_WTAIL;
                    end else begin
                        r_j <= r_j + ID_W'(1);
                    end
                end
                S_WTAIL: begin
                    r_state <= S_WFIN;
                end
                S_WFIN: begin
                    r_res.id_count   <= IDC_W'(r_idc);
                    r_res.degree_max <= DEGO_W'(r_dmax);
                    r_res.degree_min <= DEGO_W'(r_dmin);
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out            <= r_res;
                        r_out.max_id     <= r_any ? r_largest  : '0;
                        r_out.min_id     <= r_any ? r_smallest : '0;
                        r_out.edge_count <= r_edge_total;
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a degree write never goes past the list capacity
    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deg_we |-> 32'(deg_wdata) <= MAX_DEGREE)
        else $error("degree write exceeds list capacity");

    // the edge count never goes down
    a_edge_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_edge_total >= $past(r_edge_total))
        else $error("edge count decreased");

    // once an edge exists, the id range is ordered
    a_id_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> r_smallest <= r_largest)
        else $error("smallest id above largest id");

    // a finished walk has seen at least one node, so its minimum cannot top its maximum
    a_walk_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WFIN) |-> r_dmin <= r_dmax)
        else $error("summary minimum degree above maximum");

    // the neighbor RAM is only written during the two add-edge write steps
    a_nbr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nbr_we |-> (r_op == OP_ADD) && (deg_we == 1'b1))
        else $error("neighbor write outside an add-edge update");

endmodule

`default_nettype wire
